// ===== rtl/core/kau_pkg.sv =====
// ---------------------------------------------------------------------------
// kau_pkg: shared types and constants of the k-means assign/update core
// Holds the item codes, field widths and the front-to-back command struct.
// ---------------------------------------------------------------------------
`default_nettype none
package kau_pkg;
  localparam int CLUSTERS_DEF = 8;
  localparam int FEATURES_DEF = 4;
  localparam int VAL_W   = 16;
  localparam int DIST_W  = 34;
  localparam int ACC_W   = 35;
  localparam int SUM_W   = 48;
  localparam int CNT_W   = 32;
  localparam int QUO_W   = 17;

  typedef enum logic [1:0] {
    KIND_LOAD   = 2'd0,
    KIND_POINT  = 2'd1,
    KIND_FINISH = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIST,
    ST_ACCUM,
    ST_FIN_SETUP,
    ST_FIN_DIV,
    ST_FIN_WRITE,
    ST_CLEAR
  } state_t;

  // One command handed from the front to the back.
  typedef struct packed {
    logic       is_point;
    logic [2:0] cluster;
    logic [1:0] feature;
    logic [15:0] value;
    logic       last;
  } cmd_t;
endpackage
`default_nettype wire

// ===== rtl/core/kau_front.sv =====
// ---------------------------------------------------------------------------
// kau_front: command intake
// Classifies items, drops unused kinds and queues the rest for the back end.
// ---------------------------------------------------------------------------
`default_nettype none
module kau_front import kau_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_kind,
  input  wire logic [2:0]  in_cluster_index,
  input  wire logic [1:0]  in_feature_index,
  input  wire logic [15:0] in_feature_value,
  input  wire logic        in_last_feature,
  output logic             q_valid,
  output cmd_t             q_cmd,
  output logic             q_finish,
  input  wire logic        q_take,
  input  wire logic        back_idle
);
  // Two-entry queue.
  cmd_t       mem_r [2];
  logic       fin_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;

  // The host waits while the queue is full; a finish also waits for the back end.
  assign busy = (cnt_r == 2'd2) || (in_kind == KIND_FINISH && (cnt_r != 2'd0 || !back_idle));
  assign push = start && !busy && (in_kind != KIND_NONE);
  assign q_valid  = (cnt_r != 2'd0);
  assign q_cmd    = mem_r[rp_r];
  assign q_finish = fin_r[rp_r];

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = q_take ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, q_take};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      wp_r <= wp_nxt; rp_r <= rp_nxt; cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= '{is_point: in_kind == KIND_POINT, cluster: in_cluster_index,
                       feature: in_feature_index, value: in_feature_value,
                       last: in_last_feature};
      fin_r[wp_r] <= (in_kind == KIND_FINISH);
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/kau_back.sv =====
// ---------------------------------------------------------------------------
// kau_back: execution engine
// Stores centroids, labels points one cluster per cycle, accumulates sums
// and runs the finish pass through a restoring divider.
// ---------------------------------------------------------------------------
`default_nettype none
module kau_back import kau_pkg::*; #(
  parameter int CLUSTERS = CLUSTERS_DEF,
  parameter int FEATURES = FEATURES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        q_valid,
  input  cmd_t             q_cmd,
  input  wire logic        q_finish,
  output logic             q_take,
  output logic             back_idle,
  output logic             out_valid,
  output logic             out_result_kind,
  output logic [2:0]       out_label,
  output logic [33:0]      out_distance,
  output logic             out_changed
);
  localparam int CW = (CLUSTERS > 1) ? $clog2(CLUSTERS) : 1;
  localparam int FW = (FEATURES > 1) ? $clog2(FEATURES) : 1;
  localparam int N  = CLUSTERS * FEATURES;
  localparam int NW = (N > 1) ? $clog2(N) : 1;
  localparam int DIVN = SUM_W;

  // Centroids and sums in flip-flops.
  logic signed [15:0]    cen_r   [N];
  logic signed [15:0]    pt_r    [FEATURES];
  logic signed [SUM_W-1:0] sum_r [N];
  logic [CNT_W-1:0]      cnt_r   [CLUSTERS];
  logic [CLUSTERS-1:0]   used_r;

  state_t state_r, state_nxt;
  logic [CW:0] k_r;
  logic [FW:0] f_r;
  logic [ACC_W-1:0] best_d_r;
  logic [CW-1:0]    best_r;
  logic [5:0]       dc_r;
  logic [DIVN-1:0]  quo_r;
  logic [CNT_W:0]   rem_r;
  logic [DIVN-1:0]  dvd_r;
  logic             neg_r, chg_r;

  // Distance of the cluster at k_r, one cluster per cycle.
  logic [ACC_W-1:0] dsum;
  logic [CW-1:0] kk;
  assign kk = k_r[CW-1:0];
  always_comb begin
    logic signed [16:0] d;
    logic [16:0] a;
    dsum = '0;
    for (int f = 0; f < FEATURES; f++) begin
      d = 17'(cen_r[kk*FEATURES+f]) - 17'(pt_r[f]);
      a = d[16] ? 17'(-d) : 17'(d);
      dsum = dsum + ACC_W'(a) * ACC_W'(a);
    end
  end

  logic [NW-1:0] idx;
  assign idx = NW'(k_r[CW-1:0] * FEATURES + f_r[FW-1:0]);
  logic signed [SUM_W-1:0] cur_sum;
  assign cur_sum = sum_r[idx];

  logic wr_ok, pt_ok;
  assign wr_ok = (32'(q_cmd.cluster) < CLUSTERS) && (32'(q_cmd.feature) < FEATURES);
  assign pt_ok = (32'(q_cmd.feature) < FEATURES);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:
        if (q_valid) begin
          if (q_finish) state_nxt = ST_FIN_SETUP;
          else if (q_cmd.is_point && q_cmd.last) state_nxt = ST_DIST;
        end
      ST_DIST:      if (32'(k_r) == CLUSTERS - 1) state_nxt = ST_ACCUM;
      ST_ACCUM:     state_nxt = ST_IDLE;
      ST_FIN_SETUP: state_nxt = (used_r[kk]) ? ST_FIN_DIV : ST_FIN_WRITE;
      ST_FIN_DIV:   if (dc_r == 6'd0) state_nxt = ST_FIN_WRITE;
      ST_FIN_WRITE:
        if (32'(f_r) == FEATURES - 1 || !used_r[kk]) begin
          if (32'(k_r) == CLUSTERS - 1) state_nxt = ST_CLEAR;
          else state_nxt = ST_FIN_SETUP;
        end else state_nxt = ST_FIN_SETUP;
      ST_CLEAR:     state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // Outputs of the control.
  always_comb begin
    q_take    = (state_r == ST_IDLE) && q_valid;
    back_idle = (state_r == ST_IDLE);
  end

  // Mean rounding toward zero and clamp.
  logic [DIVN-1:0] qmag;
  logic signed [DIVN:0] mean;
  logic signed [15:0] mclamp;
  always_comb begin
    qmag = quo_r;
    mean = neg_r ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
    if (mean > 32767) mclamp = 16'sd32767;
    else if (mean < -32768) mclamp = -16'sd32768;
    else mclamp = mean[15:0];
  end

  logic [CNT_W:0] trial;
  assign trial = {rem_r[CNT_W-1:0], dvd_r[DIVN-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      used_r  <= '0;
      out_valid <= 1'b0;
      k_r <= '0; f_r <= '0;
      for (int i = 0; i < N; i++) sum_r[i] <= '0;
      for (int i = 0; i < CLUSTERS; i++) cnt_r[i] <= '0;
    end else begin
      state_r   <= state_nxt;
      out_valid <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          k_r <= '0; f_r <= '0; chg_r <= 1'b0;
          if (q_valid && !q_finish) begin
            if (!q_cmd.is_point && wr_ok)
              cen_r[NW'(q_cmd.cluster * FEATURES + q_cmd.feature)] <= q_cmd.value;
            if (q_cmd.is_point && pt_ok) pt_r[q_cmd.feature[FW-1:0]] <= q_cmd.value;
          end
        end
        ST_DIST: begin
          if (k_r == '0 || dsum < best_d_r) begin
            best_d_r <= dsum; best_r <= kk;
          end
          k_r <= k_r + 1'b1;
        end
        ST_ACCUM: begin
          for (int f = 0; f < FEATURES; f++) begin
            logic signed [SUM_W:0] s;
            s = (SUM_W+1)'(sum_r[32'(best_r)*FEATURES+f]) + (SUM_W+1)'(pt_r[f]);
            if (s[SUM_W] != s[SUM_W-1])
              sum_r[32'(best_r)*FEATURES+f] <= s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                                     : {1'b0, {(SUM_W-1){1'b1}}};
            else sum_r[32'(best_r)*FEATURES+f] <= s[SUM_W-1:0];
          end
          if (cnt_r[best_r] != '1) cnt_r[best_r] <= cnt_r[best_r] + 1'b1;
          used_r[best_r] <= 1'b1;
          out_valid <= 1'b1; out_result_kind <= 1'b0; out_label <= 3'(best_r);
          out_distance <= best_d_r[ACC_W-1] ? '1 : best_d_r[DIST_W-1:0];
          out_changed <= 1'b0;
        end
        ST_FIN_SETUP: begin
          neg_r <= cur_sum[SUM_W-1];
          dvd_r <= cur_sum[SUM_W-1] ? DIVN'(-cur_sum) : DIVN'(cur_sum);
          rem_r <= '0; quo_r <= '0;
          dc_r  <= 6'(DIVN - 1);
        end
        ST_FIN_DIV: begin
          // One quotient bit per cycle.
          dvd_r <= dvd_r << 1;
          if (trial >= {1'b0, cnt_r[kk]}) begin
            rem_r <= trial - {1'b0, cnt_r[kk]};
            quo_r <= {quo_r[DIVN-2:0], 1'b1};
          end else begin
            rem_r <= trial;
            quo_r <= {quo_r[DIVN-2:0], 1'b0};
          end
          dc_r <= dc_r - 1'b1;
        end
        ST_FIN_WRITE: begin
          if (used_r[kk]) begin
            if (mclamp != cen_r[idx]) chg_r <= 1'b1;
            cen_r[idx] <= mclamp;
          end
          if (32'(f_r) == FEATURES - 1 || !used_r[kk]) begin
            f_r <= '0; k_r <= k_r + 1'b1;
          end else f_r <= f_r + 1'b1;
        end
        ST_CLEAR: begin
          for (int i = 0; i < N; i++) sum_r[i] <= '0;
          for (int i = 0; i < CLUSTERS; i++) cnt_r[i] <= '0;
          used_r <= '0;
          out_valid <= 1'b1; out_result_kind <= 1'b1; out_label <= 3'd0;
          out_distance <= '0; out_changed <= chg_r;
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/kmeans_assign_update_core.sv =====
// ---------------------------------------------------------------------------
// kmeans_assign_update_core: one Lloyd k-means pass
// Front queue plus back-end engine that labels points and updates centroids.
// ---------------------------------------------------------------------------
// A load or non-last point feature is handled in the back end's idle state; a
// last feature steps the distance state once per cluster, then the sum update,
// and its result strobes out_valid for one cycle. A finish divides each used
// cluster's sums by its count with the one-bit-per-cycle divider, and waits
// until all earlier items have drained. Results cannot be held off.
`default_nettype none
module kmeans_assign_update_core import kau_pkg::*; #(
  parameter int CLUSTERS = CLUSTERS_DEF,
  parameter int FEATURES = FEATURES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_kind,
  input  wire logic [2:0]  in_cluster_index,
  input  wire logic [1:0]  in_feature_index,
  input  wire logic [15:0] in_feature_value,
  input  wire logic        in_last_feature,
  output logic             out_valid,
  output logic             out_result_kind,
  output logic [2:0]       out_label,
  output logic [33:0]      out_distance,
  output logic             out_changed
);
  logic q_valid, q_finish, q_take, back_idle;
  cmd_t q_cmd;

  kau_front u_front (
    .clk, .rst_n, .start, .busy, .in_kind, .in_cluster_index, .in_feature_index,
    .in_feature_value, .in_last_feature, .q_valid, .q_cmd, .q_finish, .q_take,
    .back_idle
  );

  kau_back #(.CLUSTERS(CLUSTERS), .FEATURES(FEATURES)) u_back (
    .clk, .rst_n, .q_valid, .q_cmd, .q_finish, .q_take, .back_idle, .out_valid,
    .out_result_kind, .out_label, .out_distance, .out_changed
  );
endmodule
`default_nettype wire
